@@ rtl/ogri_pkg.sv @@
// Shared types, constants and helpers of the occupancy grid ray-cast block.
// Used by the controller, the datapath and the top level. No dependencies.
package ogri_pkg;

  localparam int MaxWidth  = 128;
  localparam int MaxHeight = 128;
  localparam int MaxRadius = 15;
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int AW        = XW + YW;
  localparam int Depth     = MaxWidth * MaxHeight;
  // signed disc offset, holds -MaxRadius..MaxRadius with margin
  localparam int RW        = $clog2(MaxRadius + 1) + 2;
  localparam int RSQW      = 2 * RW + 1;

  typedef enum logic [2:0] {
    REG_FREE     = 3'd0,
    REG_OCCUPIED = 3'd1,
    REG_UNKNOWN  = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4,
    REG_SENSOR_X = 3'd5,
    REG_SENSOR_Y = 3'd6,
    REG_RADIUS   = 3'd7
  } reg_e;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_RAY    = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_CLEAR     = 4'd2,
    OP_RAY_RD    = 4'd3,
    OP_RAY_WR    = 4'd4,
    OP_HIT       = 4'd5,
    OP_COPY      = 4'd6,
    OP_COPY_TAIL = 4'd7,
    OP_SCAN_RD   = 4'd8,
    OP_SCAN_CHK  = 4'd9,
    OP_DISC      = 4'd10,
    OP_READ_RD   = 4'd11,
    OP_OUT       = 4'd12
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic ray_ok;
    logic ray_end;
    logic rad_zero;
    logic scan_last;
    logic occ;
    logic disc_last;
  } dp_stat_t;

  function automatic logic in_span(input logic signed [8:0] c, input logic [7:0] lim);
    return !c[8] && (c[7:0] < lim);
  endfunction

  function automatic logic [7:0] clamp_dim(input logic [7:0] v, input logic [10:0] mx);
    logic [7:0] r;
    if (v == 8'd0) r = 8'd1;
    else if ({3'b000, v} > mx) r = mx[7:0];
    else r = v;
    return r;
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic signed [8:0] x,
                                              input logic signed [8:0] y);
    return {y[YW-1:0], x[XW-1:0]};
  endfunction

endpackage

@@ rtl/occupancy_grid_raytrace_inflate_top.sv @@
// Occupancy grid with ray casting and obstacle inflation. Clear sweeps the whole store;
// a ray reads each walked cell and frees it if unknown (a ray outside the grid writes
// nothing); a read gives its result in the cycle busy drops. Finish with a nonzero radius
// copies the store, then scans each active cell and stamps a disc around each occupied
// one. After reset a clearing sweep runs while busy is high; config writes are taken
// only while idle and start is low. No stall.
module occupancy_grid_raytrace_inflate_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] cell_x_i,
  input  logic signed [8:0] cell_y_i,
  input  logic              hit_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  output logic              result_valid_o,
  output logic signed [7:0] cell_code_o,
  output logic              outside_o
);

  ogri_pkg::dp_cmd_t  dp_cmd;
  ogri_pkg::dp_stat_t dp_stat;

  // take register beats only when no command is in flight or arriving
  assign cfg_ready_o = !busy && !start;

  ogri_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .cmd_i,
    .stat_i(dp_stat), .cmd_o(dp_cmd), .busy_o(busy)
  );

  ogri_dp u_dp (
    .clk_i, .rst_ni, .cfg_valid_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .cell_x_i, .cell_y_i, .hit_i, .cmd_i(dp_cmd), .stat_o(dp_stat),
    .result_valid_o, .cell_code_o, .outside_o
  );

endmodule

@@ rtl/ogri_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ogri_ram #(
  parameter int Width = 8,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/ogri_ctrl.sv @@
// Controller state machine of the occupancy grid block.
// Depends on ogri_pkg; drives the datapath by command and reads its status.
module ogri_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       cmd_i,
  input  ogri_pkg::dp_stat_t stat_i,
  output ogri_pkg::dp_cmd_t  cmd_o,
  output logic             busy_o
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b0000_0000_0001,
    S_CLEAR     = 12'b0000_0000_0010,
    S_RAY_RD    = 12'b0000_0000_0100,
    S_RAY_WR    = 12'b0000_0000_1000,
    S_HIT       = 12'b0000_0001_0000,
    S_COPY      = 12'b0000_0010_0000,
    S_COPY_TAIL = 12'b0000_0100_0000,
    S_SCAN_RD   = 12'b0000_1000_0000,
    S_SCAN_CHK  = 12'b0001_0000_0000,
    S_DISC      = 12'b0010_0000_0000,
    S_READ      = 12'b0100_0000_0000,
    S_OUT       = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and datapath command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ogri_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = ogri_pkg::OP_LOAD;
          case (ogri_pkg::cmd_e'(cmd_i))
            ogri_pkg::CMD_CLEAR:  state_d = S_CLEAR;
            ogri_pkg::CMD_RAY:    state_d = S_RAY_RD;
            ogri_pkg::CMD_FINISH: state_d = stat_i.rad_zero ? S_IDLE : S_COPY;
            default:              state_d = S_READ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.op = ogri_pkg::OP_CLEAR;
        if (stat_i.sweep_last) state_d = S_IDLE;
      end
      S_RAY_RD: begin
        if (stat_i.ray_ok) begin
          cmd_o.op = ogri_pkg::OP_RAY_RD;
          state_d  = S_RAY_WR;
        end else begin
          state_d  = S_IDLE;
        end
      end
      S_RAY_WR: begin
        cmd_o.op = ogri_pkg::OP_RAY_WR;
        state_d  = stat_i.ray_end ? S_HIT : S_RAY_RD;
      end
      S_HIT: begin
        cmd_o.op = ogri_pkg::OP_HIT;
        state_d  = S_IDLE;
      end
      S_COPY: begin
        cmd_o.op = ogri_pkg::OP_COPY;
        if (stat_i.sweep_last) state_d = S_COPY_TAIL;
      end
      S_COPY_TAIL: begin
        cmd_o.op = ogri_pkg::OP_COPY_TAIL;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = ogri_pkg::OP_SCAN_RD;
        state_d  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd_o.op = ogri_pkg::OP_SCAN_CHK;
        if (stat_i.occ) state_d = S_DISC;
        else if (stat_i.scan_last) state_d = S_IDLE;
        else state_d = S_SCAN_RD;
      end
      S_DISC: begin
        cmd_o.op = ogri_pkg::OP_DISC;
        if (stat_i.disc_last) state_d = stat_i.scan_last ? S_IDLE : S_SCAN_RD;
      end
      S_READ: begin
        cmd_o.op = ogri_pkg::OP_READ_RD;
        state_d  = S_OUT;
      end
      S_OUT: begin
        cmd_o.op = ogri_pkg::OP_OUT;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // start with the post-reset clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

@@ rtl/ogri_dp.sv @@
// Datapath of the occupancy grid block: registers, counters, both grid stores.
// Depends on ogri_pkg and ogri_ram; steered by ogri_ctrl through dp_cmd_t.
module ogri_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  input  logic signed [8:0] cell_x_i,
  input  logic signed [8:0] cell_y_i,
  input  logic              hit_i,
  input  ogri_pkg::dp_cmd_t cmd_i,
  output ogri_pkg::dp_stat_t stat_o,
  output logic              result_valid_o,
  output logic signed [7:0] cell_code_o,
  output logic              outside_o
);

  localparam int AW = ogri_pkg::AW;
  localparam int RW = ogri_pkg::RW;

  // configuration registers
  logic [7:0] free_q, occ_q, unk_q, gw_q, gh_q;
  logic signed [8:0] sx_q, sy_q;
  logic [3:0] rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= 8'd0;
      occ_q  <= 8'd100;
      unk_q  <= 8'hFF;
      gw_q   <= 8'd128;
      gh_q   <= 8'd128;
      sx_q   <= 9'sd64;
      sy_q   <= 9'sd64;
      rad_q  <= 4'd0;
    end else if (cfg_valid_i) begin
      unique case (ogri_pkg::reg_e'(cfg_index_i))
        ogri_pkg::REG_FREE:     free_q <= cfg_data_i[7:0];
        ogri_pkg::REG_OCCUPIED: occ_q  <= cfg_data_i[7:0];
        ogri_pkg::REG_UNKNOWN:  unk_q  <= cfg_data_i[7:0];
        ogri_pkg::REG_WIDTH:    gw_q   <= cfg_data_i[7:0];
        ogri_pkg::REG_HEIGHT:   gh_q   <= cfg_data_i[7:0];
        ogri_pkg::REG_SENSOR_X: sx_q   <= cfg_data_i;
        ogri_pkg::REG_SENSOR_Y: sy_q   <= cfg_data_i;
        default:                rad_q  <= cfg_data_i[3:0];
      endcase
    end
  end

  logic [7:0] aw, ah;
  logic [3:0] rcap;
  assign aw   = ogri_pkg::clamp_dim(gw_q, 11'(ogri_pkg::MaxWidth));
  assign ah   = ogri_pkg::clamp_dim(gh_q, 11'(ogri_pkg::MaxHeight));
  assign rcap = ({28'd0, rad_q} > ogri_pkg::MaxRadius) ? 4'(ogri_pkg::MaxRadius) : rad_q;

  // working registers
  logic [AW-1:0]     ctr_q, prev_q;
  logic              pv_q;
  logic [7:0]        fill_q;
  logic signed [8:0] cx_q, cy_q, ex_q, ey_q, dx_q, dy_q;
  logic signed [10:0] err_q;
  logic              stx_q, sty_q, hit_q, ray_ok_q, outside_q;
  logic [ogri_pkg::XW-1:0] gx_q;
  logic [ogri_pkg::YW-1:0] gy_q;
  logic signed [RW-1:0] ox_q, oy_q, r_s;
  logic [ogri_pkg::RSQW-1:0] rsq_q;

  // memory ports
  logic           st_we, cp_we;
  logic [AW-1:0]  st_waddr, st_raddr, cp_waddr, cp_raddr;
  logic [7:0]     st_wdata, st_rdata, cp_rdata;

  ogri_ram #(.Width(8), .Depth(ogri_pkg::Depth)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  ogri_ram #(.Width(8), .Depth(ogri_pkg::Depth)) u_copy (
    .clk_i, .we_i(cp_we), .waddr_i(cp_waddr), .wdata_i(st_rdata),
    .raddr_i(cp_raddr), .rdata_o(cp_rdata)
  );
  assign cp_waddr = prev_q;

  // Bresenham step terms
  logic signed [11:0] e2;
  logic step_x, step_y, at_end;
  logic signed [8:0] gxs, gys, nx, ny;
  logic signed [2*RW-1:0] oxx, oyy;
  logic [ogri_pkg::RSQW-1:0] dsq;
  logic in_disc;

  assign e2     = {err_q, 1'b0};
  assign step_x = e2 > -12'(dy_q);
  assign step_y = e2 < 12'(dx_q);
  assign at_end = (cx_q == ex_q) && (cy_q == ey_q);

  // disc stamp terms
  assign r_s  = RW'({1'b0, rcap});
  assign gxs  = $signed(9'({1'b0, gx_q}));
  assign gys  = $signed(9'({1'b0, gy_q}));
  assign nx   = gxs + 9'(ox_q);
  assign ny   = gys + 9'(oy_q);
  assign oxx  = ox_q * ox_q;
  assign oyy  = oy_q * oy_q;
  assign dsq  = ogri_pkg::RSQW'(oxx) + ogri_pkg::RSQW'(oyy);
  assign in_disc = (dsq <= rsq_q) && ogri_pkg::in_span(nx, aw) && ogri_pkg::in_span(ny, ah);

  // store port steering
  always_comb begin
    st_we    = 1'b0;
    st_waddr = ogri_pkg::cell_addr(cx_q, cy_q);
    st_wdata = free_q;
    st_raddr = ctr_q;
    cp_we    = 1'b0;
    cp_raddr = {gy_q, gx_q};
    case (cmd_i.op)
      ogri_pkg::OP_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = ctr_q;
        st_wdata = fill_q;
      end
      ogri_pkg::OP_RAY_RD: st_raddr = ogri_pkg::cell_addr(cx_q, cy_q);
      ogri_pkg::OP_RAY_WR: st_we = (st_rdata == unk_q);
      ogri_pkg::OP_HIT: begin
        st_we    = hit_q;
        st_waddr = ogri_pkg::cell_addr(ex_q, ey_q);
        st_wdata = occ_q;
      end
      ogri_pkg::OP_COPY:      cp_we = pv_q;
      ogri_pkg::OP_COPY_TAIL: cp_we = pv_q;
      ogri_pkg::OP_DISC: begin
        st_we    = in_disc;
        st_waddr = ogri_pkg::cell_addr(nx, ny);
        st_wdata = occ_q;
      end
      ogri_pkg::OP_READ_RD: st_raddr = ogri_pkg::cell_addr(ex_q, ey_q);
      default: ;
    endcase
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q          <= '0;
      fill_q         <= 8'hFF;
      pv_q           <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (cmd_i.op == ogri_pkg::OP_OUT);
      case (cmd_i.op)
        ogri_pkg::OP_LOAD: begin
          ctr_q  <= '0;
          fill_q <= unk_q;
          pv_q   <= 1'b0;
        end
        ogri_pkg::OP_CLEAR: ctr_q <= ctr_q + 1'b1;
        ogri_pkg::OP_COPY: begin
          ctr_q <= ctr_q + 1'b1;
          pv_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ogri_pkg::OP_LOAD: begin
        ex_q      <= cell_x_i;
        ey_q      <= cell_y_i;
        hit_q     <= hit_i;
        cx_q      <= sx_q;
        cy_q      <= sy_q;
        dx_q      <= (cell_x_i > sx_q) ? cell_x_i - sx_q : sx_q - cell_x_i;
        dy_q      <= (cell_y_i > sy_q) ? cell_y_i - sy_q : sy_q - cell_y_i;
        err_q     <= 11'(((cell_x_i > sx_q) ? cell_x_i - sx_q : sx_q - cell_x_i))
                   - 11'(((cell_y_i > sy_q) ? cell_y_i - sy_q : sy_q - cell_y_i));
        stx_q     <= sx_q < cell_x_i;
        sty_q     <= sy_q < cell_y_i;
        ray_ok_q  <= ogri_pkg::in_span(sx_q, aw) && ogri_pkg::in_span(sy_q, ah)
                   && ogri_pkg::in_span(cell_x_i, aw) && ogri_pkg::in_span(cell_y_i, ah);
        outside_q <= !(ogri_pkg::in_span(cell_x_i, aw) && ogri_pkg::in_span(cell_y_i, ah));
        rsq_q     <= ogri_pkg::RSQW'(rcap) * ogri_pkg::RSQW'(rcap);
        gx_q      <= '0;
        gy_q      <= '0;
      end
      ogri_pkg::OP_RAY_WR: begin
        if (!at_end) begin
          err_q <= err_q - (step_x ? 11'(dy_q) : 11'sd0) + (step_y ? 11'(dx_q) : 11'sd0);
          if (step_x) cx_q <= stx_q ? cx_q + 9'sd1 : cx_q - 9'sd1;
          if (step_y) cy_q <= sty_q ? cy_q + 9'sd1 : cy_q - 9'sd1;
        end
      end
      ogri_pkg::OP_COPY: prev_q <= ctr_q;
      ogri_pkg::OP_SCAN_CHK: begin
        if (stat_o.occ) begin
          ox_q <= -r_s;
          oy_q <= -r_s;
        end else if ({1'b0, gx_q} == 8'(aw - 8'd1)) begin
          gx_q <= '0;
          gy_q <= gy_q + 1'b1;
        end else begin
          gx_q <= gx_q + 1'b1;
        end
      end
      ogri_pkg::OP_DISC: begin
        if (ox_q == r_s) begin
          ox_q <= -r_s;
          oy_q <= oy_q + 1'b1;
          if (oy_q == r_s) begin
            if ({1'b0, gx_q} == 8'(aw - 8'd1)) begin
              gx_q <= '0;
              gy_q <= gy_q + 1'b1;
            end else begin
              gx_q <= gx_q + 1'b1;
            end
          end
        end else begin
          ox_q <= ox_q + 1'b1;
        end
      end
      ogri_pkg::OP_OUT: begin
        cell_code_o <= outside_q ? occ_q : st_rdata;
        outside_o   <= outside_q;
      end
      default: ;
    endcase
  end

  // status toward the controller
  assign stat_o.sweep_last = (ctr_q == AW'(ogri_pkg::Depth - 1));
  assign stat_o.ray_ok     = ray_ok_q;
  assign stat_o.ray_end    = at_end;
  assign stat_o.rad_zero   = (rcap == 4'd0);
  assign stat_o.scan_last  = ({1'b0, gx_q} == 8'(aw - 8'd1)) && ({1'b0, gy_q} == 8'(ah - 8'd1));
  assign stat_o.occ        = (cp_rdata == occ_q);
  assign stat_o.disc_last  = (ox_q == r_s) && (oy_q == r_s);

endmodule

@@ verif/ogri_grid_checker.sv @@
// Checker for the occupancy grid block: watches the command, register and result beats,
// keeps its own grid and predicts every read. Depends on ogri_pkg.
`timescale 1ns / 100ps
module ogri_grid_checker
  import ogri_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        cmd_i,
  input  logic signed [8:0] cell_x_i,
  input  logic signed [8:0] cell_y_i,
  input  logic              hit_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              result_valid_i,
  input  logic signed [7:0] cell_code_i,
  input  logic              outside_i,
  output int                fail_count_o,
  output int                pending_reads_o
);

  typedef struct packed {
    logic signed [7:0] code;
    logic              outside;
  } read_beat_t;

  read_beat_t read_queue[$];

  logic signed [7:0] free_c, occ_c, unk_c;
  logic [7:0]        width_r, height_r;
  logic signed [8:0] sens_x, sens_y;
  logic [3:0]        radius_r;
  logic signed [7:0] grid_model [Depth];
  logic signed [7:0] grid_snap  [Depth];

  assign pending_reads_o = read_queue.size();

  function automatic int act_w();
    int w;
    w = width_r;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return w;
  endfunction

  function automatic int act_h();
    int h;
    h = height_r;
    if (h < 1) h = 1;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  function automatic bit in_grid(int x, int y);
    return x >= 0 && y >= 0 && x < act_w() && y < act_h();
  endfunction

  // Walk a Bresenham line from the sensor, freeing unknown cells and marking a hit end occupied
  task automatic walk_ray(int ex, int ey, bit hit);
    int x, y, dx, dy, stx, sty, err, e2;
    x = sens_x;
    y = sens_y;
    if (!in_grid(x, y) || !in_grid(ex, ey)) return;
    dx = ex > x ? ex - x : x - ex;
    dy = ey > y ? ey - y : y - ey;
    stx = x < ex ? 1 : -1;
    sty = y < ey ? 1 : -1;
    err = dx - dy;
    forever begin
      if (grid_model[y*MaxWidth+x] == unk_c) grid_model[y*MaxWidth+x] = free_c;
      if (x == ex && y == ey) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += stx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sty;
      end
      if (!in_grid(x, y)) break;
    end
    if (hit) grid_model[ey*MaxWidth+ex] = occ_c;
  endtask

  // Spread occupied cells of the snapshot over a disc
  task automatic grow_obstacles();
    int r, w, h, nx, ny;
    r = radius_r;
    if (r > MaxRadius) r = MaxRadius;
    if (r <= 0) return;
    w = act_w();
    h = act_h();
    grid_snap = grid_model;
    for (int gy = 0; gy < h; gy++)
      for (int gx = 0; gx < w; gx++) begin
        if (grid_snap[gy*MaxWidth+gx] != occ_c) continue;
        for (int oy = -r; oy <= r; oy++)
          for (int ox = -r; ox <= r; ox++) begin
            if (ox*ox + oy*oy > r*r) continue;
            nx = gx + ox;
            ny = gy + oy;
            if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
            grid_model[ny*MaxWidth+nx] = occ_c;
          end
      end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    read_beat_t want;
    if (!rst_ni) begin
      free_c   = 8'sd0;
      occ_c    = 8'sd100;
      unk_c    = -8'sd1;
      width_r  = 8'd128;
      height_r = 8'd128;
      sens_x   = 9'sd64;
      sens_y   = 9'sd64;
      radius_r = 4'd0;
      fail_count_o = 0;
      read_queue.delete();
      for (int i = 0; i < Depth; i++) grid_model[i] = -8'sd1;
    end else begin
      // Apply a register beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_FREE:     free_c   = cfg_data_i[7:0];
          REG_OCCUPIED: occ_c    = cfg_data_i[7:0];
          REG_UNKNOWN:  unk_c    = cfg_data_i[7:0];
          REG_WIDTH:    width_r  = cfg_data_i[7:0];
          REG_HEIGHT:   height_r = cfg_data_i[7:0];
          REG_SENSOR_X: sens_x   = cfg_data_i;
          REG_SENSOR_Y: sens_y   = cfg_data_i;
          REG_RADIUS:   radius_r = cfg_data_i[3:0];
          default: ;
        endcase
      end
      // Compare a result beat with the oldest predicted read
      if (result_valid_i) begin
        if (read_queue.size() == 0) begin
          $display("%0t: unexpected result code=%0d outside=%0b", $time, cell_code_i,
                   outside_i);
          fail_count_o++;
        end else begin
          want = read_queue.pop_front();
          if (want.code !== cell_code_i) begin
            $display("%0t: cell_code expected %0d actual %0d", $time, want.code, cell_code_i);
            fail_count_o++;
          end
          if (want.outside !== outside_i) begin
            $display("%0t: outside expected %0b actual %0b", $time, want.outside, outside_i);
            fail_count_o++;
          end
        end
      end
      // Predict an accepted command beat
      if (start_i && !busy_i) begin
        case (cmd_e'(cmd_i))
          CMD_CLEAR:  for (int i = 0; i < Depth; i++) grid_model[i] = unk_c;
          CMD_RAY:    walk_ray(cell_x_i, cell_y_i, hit_i);
          CMD_FINISH: grow_obstacles();
          default: begin
            if (in_grid(cell_x_i, cell_y_i)) begin
              want.code    = grid_model[int'(cell_y_i)*MaxWidth + int'(cell_x_i)];
              want.outside = 1'b0;
            end else begin
              want.code    = occ_c;
              want.outside = 1'b1;
            end
            read_queue.push_back(want);
          end
        endcase
      end
    end
  end

endmodule

@@ verif/tb_occupancy_grid_raytrace_inflate_top.sv @@
// Testbench top for the occupancy grid block: drives commands and register writes,
// gives the verdict. Depends on ogri_pkg, the block and ogri_grid_checker.
`timescale 1ns / 100ps
module tb_occupancy_grid_raytrace_inflate_top;
  import ogri_pkg::*;

  localparam int StallLimit = 4000000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        cmd_i = CMD_READ;
  logic signed [8:0] cell_x_i = '0;
  logic signed [8:0] cell_y_i = '0;
  logic              hit_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = REG_FREE;
  logic [8:0]        cfg_data_i = '0;
  logic              result_valid_o;
  logic signed [7:0] cell_code_o;
  logic              outside_o;
  int                fail_count, pending_reads;
  int                quiet_cycles = 0;
  int                sent_items = 0;
  int                span_w = 128, span_h = 128;

  occupancy_grid_raytrace_inflate_top uut (.*);

  ogri_grid_checker grid_chk (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .cmd_i, .cell_x_i, .cell_y_i,
    .hit_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .result_valid_i(result_valid_o), .cell_code_i(cell_code_o), .outside_i(outside_o),
    .fail_count_o(fail_count), .pending_reads_o(pending_reads)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || result_valid_o)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Register beat; valid stays high for back-to-back writes
  task automatic write_reg(reg_e idx, int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[8:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Command beat with sender idling set by the run position
  task automatic send_cmd(cmd_e c, int x, int y, bit hit);
    int idle_pct;
    idle_pct = sent_items < 267 ? 16 : (sent_items < 534 ? 59 : 0);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_i    <= c;
    cell_x_i <= x[8:0];
    cell_y_i <= y[8:0];
    hit_i    <= hit;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_items++;
  endtask

  // Hold off until every read has returned and the block is idle
  task automatic drain();
    start       <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic int pick_coord(int span);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $signed($urandom_range(0, 511) - 256);
    if (sel == 1) return $urandom_range(0, 1) ? -1 : span;
    return $urandom_range(0, span - 1);
  endfunction

  initial begin
    int widths[8]  = '{16, 1, 0, 255, 128, 8, 20, 2};
    int heights[8] = '{12, 128, 1, 7, 128, 8, 20, 255};
    int radii[8]   = '{3, 15, 5, 0, 2, 15, 7, 1};
    int finishes, clears, sel;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    // Directed: default grid, corners, outside reads, ray cases, zero-radius finish
    send_cmd(CMD_READ, 0, 0, 0);
    send_cmd(CMD_READ, 127, 127, 0);
    send_cmd(CMD_READ, -1, 0, 0);
    send_cmd(CMD_READ, 128, 5, 0);
    send_cmd(CMD_READ, -256, 255, 1);
    send_cmd(CMD_RAY, 127, 127, 1);
    send_cmd(CMD_RAY, 0, 0, 0);
    send_cmd(CMD_RAY, 64, 64, 1);
    send_cmd(CMD_RAY, 200, 3, 1);
    send_cmd(CMD_RAY, 0, 127, 1);
    send_cmd(CMD_READ, 127, 127, 0);
    send_cmd(CMD_READ, 0, 0, 0);
    send_cmd(CMD_READ, 100, 100, 0);
    send_cmd(CMD_READ, 64, 64, 0);
    send_cmd(CMD_FINISH, 0, 0, 0);
    send_cmd(CMD_READ, 64, 65, 0);
    send_cmd(CMD_CLEAR, 0, 0, 0);
    send_cmd(CMD_READ, 127, 127, 0);
    send_cmd(CMD_READ, 255, -256, 0);
    drain();

    // Phases: new register settings, then random commands
    for (int p = 0; p < 8; p++) begin
      span_w = widths[p] < 1 ? 1 : (widths[p] > 128 ? 128 : widths[p]);
      span_h = heights[p] < 1 ? 1 : (heights[p] > 128 ? 128 : heights[p]);
      write_reg(REG_FREE, p == 0 ? -128 : $urandom_range(0, 255));
      write_reg(REG_OCCUPIED, p == 0 ? 127 : $urandom_range(0, 255));
      write_reg(REG_UNKNOWN, p == 0 ? 0 : (p == 7 ? -128 : $urandom_range(0, 255)));
      write_reg(REG_WIDTH, widths[p]);
      write_reg(REG_HEIGHT, heights[p]);
      write_reg(REG_SENSOR_X, p == 2 ? -256 : $urandom_range(0, span_w - 1));
      write_reg(REG_SENSOR_Y, p == 5 ? 255 : $urandom_range(0, span_h - 1));
      write_reg(REG_RADIUS, radii[p]);
      cfg_valid_i <= 1'b0;
      // Start each phase from a known grid
      send_cmd(CMD_CLEAR, $urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1));
      finishes = 0;
      clears   = 0;
      for (int n = 0; n < 100; n++) begin
        sel = $urandom_range(0, 199);
        if (sel < 4 && finishes < 3) begin
          finishes++;
          send_cmd(CMD_FINISH, pick_coord(span_w), pick_coord(span_h), $urandom_range(0, 1));
        end else if (sel < 6 && clears < 1) begin
          clears++;
          send_cmd(CMD_CLEAR, pick_coord(span_w), pick_coord(span_h), $urandom_range(0, 1));
        end else if (sel < 110) begin
          send_cmd(CMD_RAY, pick_coord(span_w), pick_coord(span_h), $urandom_range(0, 1));
        end else begin
          send_cmd(CMD_READ, pick_coord(span_w), pick_coord(span_h), $urandom_range(0, 1));
        end
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ogri_pkg.sv
rtl/ogri_ram.sv
rtl/ogri_ctrl.sv
rtl/ogri_dp.sv
rtl/occupancy_grid_raytrace_inflate_top.sv
verif/ogri_grid_checker.sv
verif/tb_occupancy_grid_raytrace_inflate_top.sv
